>>> rtl/pbei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbei_pkg: shared types and constants
// Widths, register indexes and controller/datapath command structs for the
// plane box edge intersection block.
// ----------------------------------------------------------------------------
package pbei_pkg;
	localparam int EDGES_PER_BOX_DEF = 12;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int CRD_W = 32;
	localparam int ACC_W = 68;
	localparam int IDX_W = 4;
	localparam int CNT_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_NX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NZ = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIST = 2'd3;
	localparam logic [CRD_W-1:0] NZ_RESET = 32'h0001_0000;

	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		logic [1:0] axis;
		logic prep;
		logic div_step;
		logic finish;
	} pbei_cmd_t;

	typedef struct packed {
		logic div_done;
	} pbei_sts_t;
endpackage

>>> rtl/pbei_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbei_if: valid/ready channel
// Carries one word of a generic payload between a source and a sink.
// ----------------------------------------------------------------------------
interface pbei_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/pbei_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbei_ctrl: sequencer
// Steps the datapath through six products, the compare, the division and the result load.
// ----------------------------------------------------------------------------
module pbei_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic res_valid,
	input  logic res_ready,
	output pbei_pkg::pbei_cmd_t cmd,
	input  pbei_pkg::pbei_sts_t sts
);
	import pbei_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	logic [2:0] state_q;
	logic [2:0] step_q;
	logic res_valid_q;

	// Output register frees when taken or finishing overwrites it.
	assign in_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.axis = step_q[2:1];
		case (state_q)
			ST_MUL: begin
				cmd.mul = ~step_q[0];
				cmd.acc = step_q[0];
			end
			ST_PREP: cmd.prep = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_FIN: cmd.finish = ~res_valid_q || res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (cmd.load) begin
					state_q <= ST_MUL;
					step_q <= '0;
				end
				ST_MUL: begin
					if (step_q == 3'd5) state_q <= ST_PREP;
					step_q <= step_q + 3'd1;
				end
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: if (sts.div_done) state_q <= ST_FIN;
				ST_FIN: if (cmd.finish) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.mul, cmd.acc, cmd.prep, cmd.div_step, cmd.finish}) <= 1)
		else $error("more than one datapath command");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> res_valid_q)
		else $error("finished word not presented");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.load)
		else $error("load while busy");
endmodule

>>> rtl/pbei_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbei_dp: datapath
// Shared multipliers and accumulators, parallel test, restoring divider,
// edge and hit counters and the result register.
// ----------------------------------------------------------------------------
module pbei_dp #(
	parameter int EDGES_PER_BOX = pbei_pkg::EDGES_PER_BOX_DEF,
	parameter int FRACTION_BITS = pbei_pkg::FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  pbei_pkg::pbei_cmd_t cmd,
	output pbei_pkg::pbei_sts_t sts,
	input  logic [pbei_pkg::CRD_W-1:0] nrm_x,
	input  logic [pbei_pkg::CRD_W-1:0] nrm_y,
	input  logic [pbei_pkg::CRD_W-1:0] nrm_z,
	input  logic [pbei_pkg::CRD_W-1:0] plane_d,
	input  logic [pbei_pkg::CRD_W-1:0] sx,
	input  logic [pbei_pkg::CRD_W-1:0] sy,
	input  logic [pbei_pkg::CRD_W-1:0] sz,
	input  logic [pbei_pkg::CRD_W-1:0] ex,
	input  logic [pbei_pkg::CRD_W-1:0] ey,
	input  logic [pbei_pkg::CRD_W-1:0] ez,
	input  logic last,
	output logic [pbei_pkg::IDX_W-1:0] o_index,
	output logic o_hit,
	output logic [FRACTION_BITS:0] o_t,
	output logic [pbei_pkg::CNT_W-1:0] o_count,
	output logic o_done
);
	import pbei_pkg::*;
	localparam int TW = FRACTION_BITS + 1;
	localparam int DW = 2 * CRD_W + 2;
	localparam longint EPS = ((64'd1 << (2 * FRACTION_BITS)) + 64'd50000) / 64'd100000;
	localparam int SCW = $clog2(FRACTION_BITS + 2);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(EDGES_PER_BOX - 1);

	logic [CRD_W-1:0] sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
	logic last_q;
	logic signed [ACC_W-1:0] a_q, b_q;
	logic signed [2*CRD_W+1:0] pa_q, pb_q;
	logic signed [CRD_W:0] nsel, ssel, esel, dsel;
	logic [DW-1:0] rem_q, den_q;
	logic [TW-1:0] quo_q;
	logic [SCW-1:0] cnt_q;
	logic hit_q;
	logic [IDX_W-1:0] ecnt_q;
	logic [CNT_W-1:0] hcnt_q;
	logic signed [ACC_W-1:0] num, anum, aden;
	logic [DW:0] trial;

	always_comb begin
		case (cmd.axis)
			2'd0: begin nsel = {nrm_x[CRD_W-1], nrm_x}; ssel = {sx_q[CRD_W-1], sx_q};
				esel = {ex_q[CRD_W-1], ex_q}; end
			2'd1: begin nsel = {nrm_y[CRD_W-1], nrm_y}; ssel = {sy_q[CRD_W-1], sy_q};
				esel = {ey_q[CRD_W-1], ey_q}; end
			default: begin nsel = {nrm_z[CRD_W-1], nrm_z}; ssel = {sz_q[CRD_W-1], sz_q};
				esel = {ez_q[CRD_W-1], ez_q}; end
		endcase
		dsel = esel - ssel;
		num = (ACC_W'($signed(plane_d)) <<< FRACTION_BITS) - a_q;
		anum = num[ACC_W-1] ? -num : num;
		aden = b_q[ACC_W-1] ? -b_q : b_q;
		trial = {1'b0, rem_q} - {1'b0, den_q};
	end

	assign sts.div_done = (cnt_q == SCW'(FRACTION_BITS + 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= sx; sy_q <= sy; sz_q <= sz;
			ex_q <= ex; ey_q <= ey; ez_q <= ez;
			last_q <= last;
			a_q <= '0; b_q <= '0;
		end
		if (cmd.mul) begin
			pa_q <= (2*CRD_W+2)'(nsel * ssel);
			pb_q <= (2*CRD_W+2)'(nsel * dsel);
		end
		if (cmd.acc) begin
			a_q <= a_q + ACC_W'(pa_q);
			b_q <= b_q + ACC_W'(pb_q);
		end
		if (cmd.prep) begin
			// Parallel edges and t outside [0,1] are misses.
			hit_q <= (aden > ACC_W'(EPS)) && (num == '0 || num[ACC_W-1] == b_q[ACC_W-1])
				&& (aden >= anum);
			rem_q <= DW'(anum);
			den_q <= DW'(aden);
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step && !sts.div_done) begin
			quo_q <= {quo_q[TW-2:0], ~trial[DW]};
			rem_q <= trial[DW] ? (rem_q << 1) : (trial[DW-1:0] << 1);
			cnt_q <= cnt_q + SCW'(1);
		end
		if (cmd.finish) begin
			o_index <= ecnt_q;
			o_hit <= hit_q;
			o_t <= hit_q ? quo_q : '0;
			o_count <= (hit_q && hcnt_q != '1) ? hcnt_q + CNT_W'(1) : hcnt_q;
			o_done <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecnt_q <= '0;
			hcnt_q <= '0;
		end else if (cmd.finish) begin
			if (last_q) begin
				ecnt_q <= '0;
				hcnt_q <= '0;
			end else begin
				if (ecnt_q < IDX_MAX) ecnt_q <= ecnt_q + IDX_W'(1);
				if (hit_q && hcnt_q != '1) hcnt_q <= hcnt_q + CNT_W'(1);
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= IDX_MAX) else $error("edge counter out of range");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && last_q |=> ecnt_q == '0 && hcnt_q == '0)
		else $error("box end did not clear counters");
	a_t_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && hit_q |-> quo_q <= TW'(1 << FRACTION_BITS))
		else $error("t above one");
endmodule

>>> rtl/plane_box_edge_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_box_edge_intersect: plane versus box edge slicer
// Top level joining the configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage: program the plane normal and distance through the write port
// (index 0..3: normal_x, normal_y, normal_z, plane_distance) while idle.
// Then stream box edges on edge_in, one word per edge, marking the final
// edge with edge_last. Each edge gives exactly one word on res_out with its
// index in the box, the hit flag, t in Q1.16 and the running hit count.
// Sequence: an accepted edge goes through three multiply-accumulate passes
// (two 33x33 multipliers working side by side), the compare, the
// one-bit-per-cycle restoring divider (seventeen quotient bits and a done
// check) and the load of the output register. One edge is in flight at a
// time, so a new edge is accepted only after the previous one has finished.
// A finished word sits in the output register; the next edge is accepted
// while it waits. If it has not been taken when the next edge finishes,
// the sequencer holds that edge until the receiver takes the older word.
// Reset clears the counters and loads the default plane z = 0 (normal +z).
// ----------------------------------------------------------------------------
module plane_box_edge_intersect #(
	parameter int EDGES_PER_BOX = pbei_pkg::EDGES_PER_BOX_DEF,
	parameter int FRACTION_BITS = pbei_pkg::FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pbei_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pbei_pkg::CRD_W-1:0] cfg_data,
	pbei_if.sink edge_in,
	pbei_if.source res_out
);
	import pbei_pkg::*;

	logic [CRD_W-1:0] nx_q, ny_q, nz_q, dist_q;
	pbei_cmd_t cmd;
	pbei_sts_t sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= NZ_RESET;
			dist_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NX: nx_q <= cfg_data;
				REG_NY: ny_q <= cfg_data;
				REG_NZ: nz_q <= cfg_data;
				REG_DIST: dist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pbei_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(edge_in.valid), .in_ready(edge_in.ready),
		.res_valid(res_out.valid), .res_ready(res_out.ready),
		.cmd(cmd), .sts(sts)
	);

	pbei_dp #(.EDGES_PER_BOX(EDGES_PER_BOX), .FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.nrm_x(nx_q), .nrm_y(ny_q), .nrm_z(nz_q), .plane_d(dist_q),
		.sx(edge_in.data.start_x), .sy(edge_in.data.start_y),
		.sz(edge_in.data.start_z), .ex(edge_in.data.end_x),
		.ey(edge_in.data.end_y), .ez(edge_in.data.end_z),
		.last(edge_in.data.edge_last),
		.o_index(res_out.data.edge_index), .o_hit(res_out.data.hit),
		.o_t(res_out.data.hit_t), .o_count(res_out.data.hit_count),
		.o_done(res_out.data.box_done)
	);
endmodule
